@@ design/dpalu_pkg.sv @@
// Shared types and constants for the data-processing ALU.
`timescale 1ns / 1ps

package dpalu_pkg;

  // Operation codes
  localparam logic [3:0] ACT_AND = 4'd0;
  localparam logic [3:0] ACT_EOR = 4'd1;
  localparam logic [3:0] ACT_SUB = 4'd2;
  localparam logic [3:0] ACT_RSB = 4'd3;
  localparam logic [3:0] ACT_ADD = 4'd4;
  localparam logic [3:0] ACT_ADC = 4'd5;
  localparam logic [3:0] ACT_SBC = 4'd6;
  localparam logic [3:0] ACT_RSC = 4'd7;
  localparam logic [3:0] ACT_ORR = 4'd8;
  localparam logic [3:0] ACT_MOV = 4'd9;
  localparam logic [3:0] ACT_BIC = 4'd10;
  localparam logic [3:0] ACT_MVN = 4'd11;

  localparam int          DATA_W   = 32;
  localparam int          SIGN_BIT = 31;
  localparam int          REG_CNT  = 16;
  localparam logic [3:0]  PC_INDEX = 4'd15;

  typedef logic [DATA_W-1:0] word_t;

  // Condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // Outcome of one operation, from the datapath to the top level
  typedef struct packed {
    logic   wr_en;
    flags_t flags;
    logic   restore;
  } alu_status_t;

endpackage

@@ design/arm_data_processing_alu_unit.sv @@
// Top level: input register, ALU pass, register file, flags and result register.
`timescale 1ns / 1ps

// ARM data-processing execute stage. One operation is accepted every cycle
// while in_stall is low. The input register holds the operation; from it,
// Rn is read from the 16 x 32 register file and passed through one 32-bit
// add or logic step, and the result register is loaded while Rd and the
// NZCV flags are written. An operation always sees the register file and
// flags left by the one before it. The result register holds while
// out_stall is high, and the input keeps flowing as long as that register
// is free or being emptied. The saved-status mode bit is written through the
// cfg port, which is always ready.
module arm_data_processing_alu_unit
  import dpalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_mode_has_saved_status,
  // operation input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [3:0]  in_src_index,
  input  logic [3:0]  in_dest_index,
  input  logic [31:0] in_shifter_operand,
  input  logic        in_shifter_carry,
  input  logic        in_set_flags,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_c,
  output logic        out_flag_v,
  output logic        out_restore_status
);

  // Input register
  logic        s1_valid_r;
  logic [3:0]  s1_action_r;
  logic [3:0]  s1_src_r;
  logic [3:0]  s1_dest_r;
  word_t       s1_op2_r;
  logic        s1_shc_r;
  logic        s1_s_r;

  // Architectural state
  word_t       regs_r [REG_CNT];
  flags_t      flags_r;
  logic        mode_r;

  // Result register
  logic        out_valid_r;
  word_t       out_result_r;
  flags_t      out_flags_r;
  logic        out_restore_r;

  logic        adv;
  logic        adv_fire;
  logic        in_fire;
  word_t       alu_result;
  alu_status_t alu_status;

  // Handshake
  assign adv       = ~out_valid_r | ~out_stall;
  assign adv_fire  = s1_valid_r & adv;
  assign in_stall  = s1_valid_r & ~adv;
  assign in_fire   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_mode_has_saved_status;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_src_r    <= in_src_index;
      s1_dest_r   <= in_dest_index;
      s1_op2_r    <= in_shifter_operand;
      s1_shc_r    <= in_shifter_carry;
      s1_s_r      <= in_set_flags;
    end
  end

  // Datapath
  dpalu_core u_core (
    .action                (s1_action_r),
    .dest_index            (s1_dest_r),
    .rn                    (regs_r[s1_src_r]),
    .op2                   (s1_op2_r),
    .shifter_carry         (s1_shc_r),
    .set_flags             (s1_s_r),
    .flags_in              (flags_r),
    .mode_has_saved_status (mode_r),
    .result                (alu_result),
    .status                (alu_status)
  );

  // Register file and flags, written as the operation leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CNT; i++) begin
        regs_r[i] <= '0;
      end
      flags_r <= '0;
    end else if (adv_fire) begin
      if (alu_status.wr_en) begin
        regs_r[s1_dest_r] <= alu_result;
      end
      flags_r <= alu_status.flags;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_fire) begin
      out_result_r  <= alu_result;
      out_flags_r   <= alu_status.flags;
      out_restore_r <= alu_status.restore;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_flag_n         = out_flags_r.n;
  assign out_flag_z         = out_flags_r.z;
  assign out_flag_c         = out_flags_r.c;
  assign out_flag_v         = out_flags_r.v;
  assign out_restore_status = out_restore_r;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_fire |=> $stable(flags_r))
    else $error("flags changed without an operation completing");

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r)
    else $error("result valid after transfer with nothing behind it");

  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv_fire |=> out_valid_r)
    else $error("completed operation did not reach the result register");

endmodule

@@ design/dpalu_core.sv @@
// Combinational datapath: logical ops, 32-bit adder and flag generation.
`timescale 1ns / 1ps

module dpalu_core
  import dpalu_pkg::*;
(
  input  logic [3:0]  action,
  input  logic [3:0]  dest_index,
  input  word_t       rn,
  input  word_t       op2,
  input  logic        shifter_carry,
  input  logic        set_flags,
  input  flags_t      flags_in,
  input  logic        mode_has_saved_status,
  output word_t       result,
  output alu_status_t status
);

  word_t        add_a;
  word_t        add_b;
  logic         add_cin;
  logic [32:0]  sum;
  word_t        sum_lo;
  logic         is_arith;
  logic         valid_op;
  logic         add_v;

  // Operand selection for the shared adder; subtracts use a + ~b + cin
  always_comb begin
    add_a    = rn;
    add_b    = op2;
    add_cin  = 1'b0;
    is_arith = 1'b1;
    unique case (action)
      ACT_SUB: begin add_a = rn;  add_b = ~op2; add_cin = 1'b1;        end
      ACT_RSB: begin add_a = op2; add_b = ~rn;  add_cin = 1'b1;        end
      ACT_ADD: begin add_a = rn;  add_b = op2;  add_cin = 1'b0;        end
      ACT_ADC: begin add_a = rn;  add_b = op2;  add_cin = flags_in.c;  end
      ACT_SBC: begin add_a = rn;  add_b = ~op2; add_cin = flags_in.c;  end
      ACT_RSC: begin add_a = op2; add_b = ~rn;  add_cin = flags_in.c;  end
      default: is_arith = 1'b0;
    endcase
  end

  assign sum    = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign sum_lo = sum[DATA_W-1:0];
  assign add_v  = ~(add_a[SIGN_BIT] ^ add_b[SIGN_BIT]) & (add_a[SIGN_BIT] ^ sum_lo[SIGN_BIT]);

  // Result mux; undefined codes give zero and no write
  always_comb begin
    valid_op = 1'b1;
    result   = '0;
    unique case (action)
      ACT_AND: result = rn & op2;
      ACT_EOR: result = rn ^ op2;
      ACT_ORR: result = rn | op2;
      ACT_MOV: result = op2;
      ACT_BIC: result = rn & ~op2;
      ACT_MVN: result = ~op2;
      ACT_SUB, ACT_RSB, ACT_ADD, ACT_ADC, ACT_SBC, ACT_RSC: result = sum_lo;
      default: valid_op = 1'b0;
    endcase
  end

  // Flag update; S with Rd = r15 keeps the flags and, when the mode has a saved status, asks for a status restore
  always_comb begin
    status.wr_en   = valid_op;
    status.flags   = flags_in;
    status.restore = 1'b0;
    if (valid_op && set_flags) begin
      if (dest_index == PC_INDEX) begin
        status.restore = mode_has_saved_status;
      end else begin
        status.flags.n = result[SIGN_BIT];
        status.flags.z = (result == '0);
        status.flags.c = is_arith ? sum[DATA_W] : shifter_carry;
        status.flags.v = is_arith ? add_v : flags_in.v;
      end
    end
  end

endmodule
